// ----- hw/rtl/mrlt_pkg.sv -----
// Package for the markdown run-length tokenizer.
// Holds the request and result types, token kinds, sizes and byte classification.
// No dependencies.
package mrlt_pkg;

  localparam int unsigned TokenCapacity = 1024;
  localparam int unsigned UsedBits      = $clog2(TokenCapacity + 1);
  localparam int unsigned SlotBits      = 10;
  localparam int unsigned CountBits     = 16;
  localparam int unsigned PosBits       = 16;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrBits  = $clog2(QueueDepth);

  typedef enum logic [3:0] {
    KindHash      = 4'd0,
    KindUnderline = 4'd1,
    KindStar      = 4'd2,
    KindTick      = 4'd3,
    KindDash      = 4'd4,
    KindNewline   = 4'd5,
    KindLBracket  = 4'd6,
    KindRBracket  = 4'd7,
    KindLParen    = 4'd8,
    KindRParen    = 4'd9,
    KindQuote     = 4'd10,
    KindText      = 4'd11,
    KindBang      = 4'd12
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_document;
  } req_t;

  typedef struct packed {
    kind_e                token_kind;
    logic [SlotBits-1:0]  token_slot;
    logic [CountBits-1:0] run_length;
    logic [PosBits-1:0]   line_number;
    logic [PosBits-1:0]   start_column;
    logic                 capacity_overflow;
    logic                 last_of_item;
  } res_t;

  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } pair_t;

  function automatic kind_e classify(input logic [7:0] b);
    kind_e k;
    case (b)
      8'h23:   k = KindHash;
      8'h5f:   k = KindUnderline;
      8'h2a:   k = KindStar;
      8'h60:   k = KindTick;
      8'h2d:   k = KindDash;
      8'h0a:   k = KindNewline;
      8'h5b:   k = KindLBracket;
      8'h5d:   k = KindRBracket;
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h3e:   k = KindQuote;
      8'h21:   k = KindBang;
      default: k = KindText;
    endcase
    return k;
  endfunction

  function automatic logic merges(input kind_e k);
    return (k inside {KindHash, KindUnderline, KindStar, KindTick, KindDash, KindText});
  endfunction

endpackage

// ----- hw/rtl/mrlt_front.sv -----
// Front end of the tokenizer: classifies each byte, merges runs and tracks position.
// Produces up to two results per request as one queue entry. Depends on mrlt_pkg.
module mrlt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  mrlt_pkg::req_t item_i,
  input  logic           q_full_i,
  output logic           full,
  output logic           q_push_o,
  output mrlt_pkg::pair_t q_data_o
);
  import mrlt_pkg::*;

  logic                 run_open_q, run_open_d;
  kind_e                run_kind_q, run_kind_d;
  logic [CountBits-1:0] run_count_q, run_count_d;
  logic [PosBits-1:0]   run_line_q, run_line_d;
  logic [PosBits-1:0]   run_col_q, run_col_d;
  logic [SlotBits-1:0]  run_slot_q, run_slot_d;
  logic [PosBits-1:0]   line_q, line_d;
  logic [PosBits-1:0]   col_q, col_d;
  logic [UsedBits-1:0]  used_q, used_d;
  logic                 ovf_q, ovf_d;

  kind_e                kind;
  logic                 accept;
  logic                 have_old, have_new;
  res_t                 old_tok, new_tok;
  logic [PosBits-1:0]   col_inc;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign kind   = classify(item_i.data_byte);
  assign col_inc = (col_q == '1) ? col_q : col_q + 1'b1;

  always_comb begin
    run_open_d  = run_open_q;
    run_kind_d  = run_kind_q;
    run_count_d = run_count_q;
    run_line_d  = run_line_q;
    run_col_d   = run_col_q;
    run_slot_d  = run_slot_q;
    line_d      = line_q;
    col_d       = col_q;
    used_d      = used_q;
    ovf_d       = ovf_q;
    have_old    = 1'b0;
    have_new    = 1'b0;

    old_tok = '{token_kind: run_kind_q, token_slot: run_slot_q, run_length: run_count_q,
                line_number: run_line_q, start_column: run_col_q,
                capacity_overflow: 1'b0, last_of_item: 1'b0};
    new_tok = '{token_kind: kind, token_slot: used_q[SlotBits-1:0],
                run_length: CountBits'(1), line_number: line_q, start_column: col_q,
                capacity_overflow: 1'b0, last_of_item: 1'b0};

    if (item_i.end_of_document) begin
      have_old   = run_open_q;
      run_open_d = 1'b0;
      line_d     = '0;
      col_d      = '0;
      used_d     = '0;
      ovf_d      = 1'b0;
    end else if (!ovf_q) begin
      if (run_open_q && kind == run_kind_q && merges(kind)) begin
        run_count_d = (run_count_q == '1) ? run_count_q : run_count_q + 1'b1;
        col_d       = col_inc;
      end else begin
        have_old   = run_open_q;
        run_open_d = 1'b0;
        if (used_q >= UsedBits'(TokenCapacity)) begin
          have_new = 1'b1;
          new_tok  = '{token_kind: KindHash, token_slot: '0, run_length: '0,
                       line_number: '0, start_column: '0,
                       capacity_overflow: 1'b1, last_of_item: 1'b0};
          ovf_d    = 1'b1;
        end else begin
          used_d = used_q + 1'b1;
          if (merges(kind)) begin
            run_open_d  = 1'b1;
            run_kind_d  = kind;
            run_count_d = CountBits'(1);
            run_line_d  = line_q;
            run_col_d   = col_q;
            run_slot_d  = used_q[SlotBits-1:0];
            col_d       = col_inc;
          end else begin
            have_new = 1'b1;
            if (kind == KindNewline) begin
              line_d = (line_q == '1) ? line_q : line_q + 1'b1;
              col_d  = '0;
            end else begin
              col_d = col_inc;
            end
          end
        end
      end
    end

    q_data_o.two = have_old && have_new;
    if (have_old) begin
      q_data_o.first  = old_tok;
      q_data_o.second = new_tok;
    end else begin
      q_data_o.first  = new_tok;
      q_data_o.second = new_tok;
    end
    if (q_data_o.two) begin
      q_data_o.second.last_of_item = 1'b1;
    end else begin
      q_data_o.first.last_of_item = 1'b1;
    end
    q_push_o = accept && (have_old || have_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q  <= 1'b0;
      run_kind_q  <= KindHash;
      run_count_q <= '0;
      run_line_q  <= '0;
      run_col_q   <= '0;
      run_slot_q  <= '0;
      line_q      <= '0;
      col_q       <= '0;
      used_q      <= '0;
      ovf_q       <= 1'b0;
    end else if (accept) begin
      run_open_q  <= run_open_d;
      run_kind_q  <= run_kind_d;
      run_count_q <= run_count_d;
      run_line_q  <= run_line_d;
      run_col_q   <= run_col_d;
      run_slot_q  <= run_slot_d;
      line_q      <= line_d;
      col_q       <= col_d;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
    end
  end

endmodule

// ----- hw/rtl/mrlt_queue.sv -----
// Short queue of result pairs between the front end and the back end.
// Depends on mrlt_pkg.
module mrlt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrlt_pkg::pair_t data_i,
  input  logic            deq_i,
  output logic            full_o,
  output logic            empty_o,
  output mrlt_pkg::pair_t head_o
);
  import mrlt_pkg::*;

  pair_t                   mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrBits:0]   cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == (QueuePtrBits + 1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = deq_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueuePtrBits + 1)'(do_push) - (QueuePtrBits + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/mrlt_back.sv -----
// Back end of the tokenizer: presents the queued results one at a time.
// Depends on mrlt_pkg.
module mrlt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  mrlt_pkg::pair_t q_head_i,
  input  logic            pop,
  output logic            q_deq_o,
  output logic            empty,
  output mrlt_pkg::res_t  result_o
);
  import mrlt_pkg::*;

  logic sel_q, sel_d;
  logic take;

  assign empty    = q_empty_i;
  assign result_o = sel_q ? q_head_i.second : q_head_i.first;
  assign take     = pop && !q_empty_i;

  always_comb begin
    sel_d   = sel_q;
    q_deq_o = 1'b0;
    if (take) begin
      if (q_head_i.two && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d   = 1'b0;
        q_deq_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// ----- hw/rtl/markdown_run_length_tokenizer.sv -----
// Markdown run-length tokenizer, top level. Depends on mrlt_pkg, mrlt_front,
// mrlt_queue and mrlt_back.
// A result is registered in the queue before it is visible at the result port.
// Throughput: one request per cycle while full is low; a request that closes a run
// and emits a one-byte token or the overflow result gives two results on the result
// port, and a four-entry queue absorbs that.
// Reset clears the run state, position counters, slot count and the queue.
module markdown_run_length_tokenizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  mrlt_pkg::req_t item_i,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output mrlt_pkg::res_t result_o
);
  import mrlt_pkg::*;

  logic  q_push, q_full, q_empty, q_deq;
  pair_t q_data, q_head;

  mrlt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .q_full_i (q_full),
    .full     (full),
    .q_push_o (q_push),
    .q_data_o (q_data)
  );

  mrlt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_data),
    .deq_i   (q_deq),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  mrlt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .pop       (pop),
    .q_deq_o   (q_deq),
    .empty     (empty),
    .result_o  (result_o)
  );

endmodule
